>>> sv/tpts_pkg.sv
// ============================================================================
// tpts_pkg
// Shared types and codes of the tick priority task scheduler: request and
// result payloads, function codes and the controller/datapath interface.
// ============================================================================
package tpts_pkg;

   localparam int FUNC_W    = 3;
   localparam int TASK_ID_W = 3;
   localparam int VALUE_W   = 16;

   typedef logic [TASK_ID_W-1:0] task_id_type;
   typedef logic [VALUE_W-1:0]   value_type;

   // Function codes of a request. Codes above FUNC_TICKS change no task state.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_SCHEDULE = 3'd0,
      FUNC_LOAD     = 3'd1,
      FUNC_SLEEP    = 3'd2,
      FUNC_WAIT     = 3'd3,
      FUNC_TICKS    = 3'd4
   } func_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      task_id_type       task_index;
      value_type         value;
   } req_type;

   typedef struct packed {
      task_id_type running_task;
      logic        none_ready;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;      // a request is taken this cycle
      logic scan_en;     // process the task under the sweep counter in a pass
      logic refill_en;   // refill the task under the sweep counter
      logic pass_clear;  // clear the pass accumulators before the next sweep
      logic dec_skip;    // with pass_clear: next pass skips idle passes
      logic commit;      // the picked task becomes the running task
      logic fail;        // no task can ever be picked
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;        // sweep counter is on the last task
      logic found;       // the pass picked a task
      logic any_pri;     // some candidate has a nonzero priority
      logic skip_ok;     // some free sleeper will still wake up
   } dp_stat_type;

endpackage

>>> sv/tpts_ctrl.sv
// ============================================================================
// tpts_ctrl
// Controller of the scheduler: sequences scan and refill sweeps and the
// one-cycle result strobe.
// ============================================================================
module tpts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [tpts_pkg::FUNC_W-1:0] func,
   input  tpts_pkg::dp_stat_type stat,
   output tpts_pkg::dp_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_REFILL = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign accept    = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.accept = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (func == tpts_pkg::FUNC_SCHEDULE) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.found) begin
               cmd.commit = 1'b1;
               state_in   = ST_RESP;
            end else if (stat.any_pri) begin
               cmd.pass_clear = 1'b1;
               state_in       = ST_REFILL;
            end else if (stat.skip_ok) begin
               cmd.pass_clear = 1'b1;
               cmd.dec_skip   = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               cmd.fail = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_REFILL: begin
            cmd.refill_en = 1'b1;
            if (stat.last) begin
               state_in = ST_SCAN;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/tpts_dp.sv
// ============================================================================
// tpts_dp
// Datapath of the scheduler: task tables, running task, sweep counter and
// the per-pass accumulators for the best task and the next wake-up.
// ============================================================================
module tpts_dp #(
   parameter int TASK_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tpts_pkg::req_type     req,
   input  tpts_pkg::dp_cmd_type  cmd,
   output tpts_pkg::dp_stat_type stat,
   output tpts_pkg::rsp_type     rsp
);

   localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

   typedef logic [IW-1:0] idx_type;

   tpts_pkg::value_type ticks_ff [TASK_COUNT];
   tpts_pkg::value_type ticks_in [TASK_COUNT];
   tpts_pkg::value_type prio_ff  [TASK_COUNT];
   tpts_pkg::value_type prio_in  [TASK_COUNT];
   tpts_pkg::value_type sleep_ff [TASK_COUNT];
   tpts_pkg::value_type sleep_in [TASK_COUNT];
   logic                wait_ff  [TASK_COUNT];
   logic                wait_in  [TASK_COUNT];

   idx_type             cur_ff, cur_in;
   logic                none_ff, none_in;
   idx_type             cnt_ff, cnt_in;
   tpts_pkg::value_type best_ff, best_in;
   idx_type             pick_ff, pick_in;
   logic                anypri_ff, anypri_in;
   tpts_pkg::value_type dmin_ff, dmin_in;
   tpts_pkg::value_type dec_ff, dec_in;

   tpts_pkg::value_type s_cur;
   tpts_pkg::value_type s_new;
   logic                cand_scan;
   logic                cand_refill;
   logic                last;
   logic                idx_ok;
   idx_type             req_idx;

   assign last        = (cnt_ff == idx_type'(TASK_COUNT - 1));
   assign s_cur       = sleep_ff[cnt_ff];
   // A pass decrements by one; after idle passes were skipped it takes the
   // whole distance to the next wake-up at once, saturating at zero.
   assign s_new       = (s_cur > dec_ff) ? (s_cur - dec_ff) : '0;
   assign cand_scan   = (s_new == '0) && !wait_ff[cnt_ff];
   assign cand_refill = (s_cur == '0) && !wait_ff[cnt_ff];
   assign idx_ok      = (32'(req.task_index) < TASK_COUNT);
   assign req_idx     = idx_type'(req.task_index);

   assign stat.last    = last;
   assign stat.found   = (best_ff != '0);
   assign stat.any_pri = anypri_ff;
   assign stat.skip_ok = (dmin_ff != '0);

   assign rsp.running_task = tpts_pkg::task_id_type'(cur_ff);
   assign rsp.none_ready   = none_ff;

   always_comb begin
      ticks_in  = ticks_ff;
      prio_in   = prio_ff;
      sleep_in  = sleep_ff;
      wait_in   = wait_ff;
      cur_in    = cur_ff;
      none_in   = none_ff;
      cnt_in    = cnt_ff;
      best_in   = best_ff;
      pick_in   = pick_ff;
      anypri_in = anypri_ff;
      dmin_in   = dmin_ff;
      dec_in    = dec_ff;

      if (cmd.accept) begin
         none_in = 1'b0;
         case (req.func)
            tpts_pkg::FUNC_SCHEDULE: begin
               cnt_in    = '0;
               best_in   = '0;
               pick_in   = '0;
               anypri_in = 1'b0;
               dmin_in   = '0;
               dec_in    = tpts_pkg::value_type'(1);
            end
            tpts_pkg::FUNC_LOAD: begin
               if (idx_ok) begin
                  prio_in[req_idx]  = req.value;
                  ticks_in[req_idx] = req.value;
               end
            end
            tpts_pkg::FUNC_SLEEP: begin
               sleep_in[cur_ff] = req.value;
            end
            tpts_pkg::FUNC_WAIT: begin
               if (idx_ok) begin
                  wait_in[req_idx] = req.value[0];
               end
            end
            tpts_pkg::FUNC_TICKS: begin
               if (idx_ok) begin
                  ticks_in[req_idx] = req.value;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan_en) begin
         sleep_in[cnt_ff] = s_new;
         if (cand_scan && (ticks_ff[cnt_ff] > best_ff)) begin
            best_in = ticks_ff[cnt_ff];
            pick_in = cnt_ff;
         end
         if (cand_scan && (prio_ff[cnt_ff] != '0)) begin
            anypri_in = 1'b1;
         end
         if (!wait_ff[cnt_ff] && (s_new != '0) && ((dmin_ff == '0) || (s_new < dmin_ff))) begin
            dmin_in = s_new;
         end
      end

      if (cmd.refill_en && cand_refill) begin
         ticks_in[cnt_ff] = prio_ff[cnt_ff];
      end

      if (cmd.scan_en || cmd.refill_en) begin
         cnt_in = last ? '0 : (cnt_ff + idx_type'(1));
      end

      if (cmd.pass_clear) begin
         best_in   = '0;
         pick_in   = '0;
         anypri_in = 1'b0;
         dmin_in   = '0;
         dec_in    = cmd.dec_skip ? dmin_ff : tpts_pkg::value_type'(1);
      end

      if (cmd.commit) begin
         cur_in = pick_ff;
      end

      if (cmd.fail) begin
         none_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_COUNT; i++) begin
            ticks_ff[i] <= '0;
            prio_ff[i]  <= '0;
            sleep_ff[i] <= '0;
            wait_ff[i]  <= 1'b0;
         end
         cur_ff  <= '0;
         none_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         ticks_ff <= ticks_in;
         prio_ff  <= prio_in;
         sleep_ff <= sleep_in;
         wait_ff  <= wait_in;
         cur_ff   <= cur_in;
         none_ff  <= none_in;
         cnt_ff   <= cnt_in;
      end
      best_ff   <= best_in;
      pick_ff   <= pick_in;
      anypri_ff <= anypri_in;
      dmin_ff   <= dmin_in;
      dec_ff    <= dec_in;
   end

endmodule

>>> sv/tick_priority_task_scheduler_top.sv
// ============================================================================
// tick_priority_task_scheduler_top
// Priority scheduler over TASK_COUNT tasks with remaining ticks, sleep
// countdowns and wait flags; a controller sequences sweeps over a datapath.
// ============================================================================
//
//   Channel   Ports                          Handshake
//   --------  -----------------------------  --------------------------------
//   request   start, busy, req_payload       taken when start is high and
//                                            busy is low
//   result    rsp_valid, rsp_payload         one result per request, shown
//                                            for exactly one cycle
//
// A request that only loads task state is answered in the cycle right after
// its acceptance, and the next request can be taken once that result cycle
// has passed. A schedule request runs scan sweeps, each followed by a
// decision state, with a refill sweep between passes where needed, and ends
// in the result state; the sweep counter walks the task table one entry per
// cycle.
// Reset is synchronous and active high and clears all task state. The result
// cannot be stalled; busy stays high until the result cycle has passed.
//
module tick_priority_task_scheduler_top #(
   parameter int TASK_COUNT = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  tpts_pkg::req_type   req_payload,
   output logic                rsp_valid,
   output tpts_pkg::rsp_type   rsp_payload
);

   tpts_pkg::dp_cmd_type  cmd;
   tpts_pkg::dp_stat_type stat;

   // The controller walks through scan passes. A pass decrements every sleep
   // count and tracks the first task with the strictly greatest ticks among
   // tasks that are neither sleeping nor waiting. When a pass picks nothing,
   // either the candidates are refilled from their priorities (the following
   // pass then always picks), or the passes up to the next wake-up of a
   // sleeper that is not waiting are folded into the next pass, or the
   // request ends with none_ready. Every folded pass wakes at least one such
   // sleeper, so a request ends within TASK_COUNT + 3 passes.
   tpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .func      (req_payload.func),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath holds the task tables and applies the load requests in
   // the cycle the request is taken.
   tpts_dp #(
      .TASK_COUNT (TASK_COUNT)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_payload),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp_payload)
   );

   // A request other than schedule is answered in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.func != tpts_pkg::FUNC_SCHEDULE)) |=> rsp_valid)
      else $error("load request not answered in the next cycle");

   // A request other than schedule never moves the running task.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.func != tpts_pkg::FUNC_SCHEDULE))
         |=> $stable(rsp_payload.running_task))
      else $error("running task changed by a load request");

   // When no task can be picked, the running task keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.none_ready) |-> $stable(rsp_payload.running_task))
      else $error("running task changed although none was ready");

   // The block only becomes free again right after its result strobe.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid))
      else $error("busy dropped without a result");

endmodule
